@@ rtl/lhist_pkg.sv @@
// Shared constants, types and helpers for the log2 latency histogram.
package lhist_pkg;

  localparam int NUM_BINS  = 32;
  localparam int NS_PER_MS = 1000000;

  localparam int CMD_W   = 2;
  localparam int TS_W    = 64;
  localparam int SEL_W   = 5;
  localparam int BIN_W   = 5;
  localparam int COUNT_W = 32;

  localparam int ADDR_W = $clog2(NUM_BINS);
  // wide enough to hold any select value and NUM_BINS itself
  localparam int IDX_W  = ((ADDR_W > SEL_W) ? ADDR_W : SEL_W) + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic              is_read;
    logic              oob;
    logic [ADDR_W-1:0] addr;
    logic [BIN_W-1:0]  out_bin;
  } lhist_job_t;

  // Lower edge of bin j in ns: NS_PER_MS * 2^j. Values past 2^64 saturate to
  // 2^64 so a 65-bit compare against the elapsed time never hits them.
  function automatic logic [TS_W:0] bin_thresh(input int j);
    logic [127:0] t;
    t = 128'(NS_PER_MS) << j;
    if (t[127:TS_W] != '0) begin
      bin_thresh = {1'b1, {TS_W{1'b0}}};
    end else begin
      bin_thresh = {1'b0, t[TS_W-1:0]};
    end
  endfunction

endpackage

@@ rtl/lhist_if.sv @@
// Handshake channels for event input and histogram results.
interface lhist_in_if
  import lhist_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [TS_W-1:0]  timestamp;
  logic [SEL_W-1:0] bin_select;

  modport source(output valid, cmd, timestamp, bin_select, input ready);
  modport sink(input valid, cmd, timestamp, bin_select, output ready);
endinterface

interface lhist_out_if
  import lhist_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BIN_W-1:0]   bin;
  logic [COUNT_W-1:0] count;

  modport source(output valid, bin, count, input ready);
  modport sink(input valid, bin, count, output ready);
endinterface

@@ rtl/log2_latency_histogram_top.sv @@
// Top level of the log2 latency histogram engine.
//
//  channel | dir | word                          | handshake
//  in_ch   | in  | cmd, timestamp, bin_select    | valid/ready
//  out_ch  | out | bin, count                    | valid/ready
//
// One word per cycle is accepted and one result per cycle delivered when
// nothing stalls; an exit or read result passes through the two front stages,
// the job queue, the bin read stage and the result register.
// Entry words update the start time and leave no result.
// Synchronous active-low reset clears start time and all bins at once
// through per-bin valid flags; no clearing pass is needed.
// A stalled output fills the four-entry queue before in_ch.ready drops.
module log2_latency_histogram_top
  import lhist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lhist_in_if.sink    in_ch,
  lhist_out_if.source out_ch
);

  logic       push;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  lhist_job_t push_job;
  lhist_job_t head_job;

  lhist_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  lhist_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  lhist_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (head_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/lhist_fifo.sv @@
// Small job queue between the classify front end and the histogram back end.
module lhist_fifo
  import lhist_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lhist_job_t push_job,
  output logic       full,
  input  logic       pop,
  output lhist_job_t head_job,
  output logic       empty
);

  lhist_job_t            q_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r;
  logic [FIFO_PTR_W:0]   count_nxt;

  assign full     = (count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = q_mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

@@ rtl/lhist_front.sv @@
// Front end: takes event words, tracks start time, maps elapsed time (or a read select) to a bin.
module lhist_front
  import lhist_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lhist_in_if.sink   in_ch,
  output logic       push,
  output lhist_job_t push_job,
  input  logic       q_full
);

  logic [TS_W-1:0]     start_r;
  logic                f1_valid_r;
  logic                f1_read_r;
  logic [TS_W-1:0]     f1_diff_r;
  logic [SEL_W-1:0]    f1_sel_r;
  logic                f2_valid_r;
  logic                f2_read_r;
  logic [NUM_BINS-1:1] f2_therm_r;
  logic [SEL_W-1:0]    f2_sel_r;

  logic                adv;
  logic                in_fire;
  logic                is_entry;
  logic                is_job;
  logic                is_read;
  logic [NUM_BINS-1:1] therm;
  logic [ADDR_W-1:0]   slot;
  logic [IDX_W-1:0]    sel_idx;

  assign adv         = !f2_valid_r || !q_full;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    is_entry = 1'b0;
    is_job   = 1'b0;
    is_read  = 1'b0;
    unique case (in_ch.cmd)
      CMD_ENTRY: is_entry = 1'b1;
      CMD_EXIT:  is_job   = 1'b1;
      CMD_READ: begin
        is_job  = 1'b1;
        is_read = 1'b1;
      end
      default: ;
    endcase
  end

  // elapsed >= 1e6 * 2^j  <=>  floor(ms) >= 2^j; result is a thermometer code
  always_comb begin
    for (int j = 1; j < NUM_BINS; j++) begin
      therm[j] = ({1'b0, f1_diff_r} >= bin_thresh(j));
    end
  end

  // highest set bit; clamps to NUM_BINS-1 by construction
  always_comb begin
    slot = '0;
    for (int j = 1; j < NUM_BINS; j++) begin
      if (f2_therm_r[j]) begin
        slot = ADDR_W'(j);
      end
    end
  end

  assign sel_idx = IDX_W'(f2_sel_r);

  always_comb begin
    push_job.is_read = f2_read_r;
    push_job.oob     = f2_read_r && (sel_idx >= IDX_W'(NUM_BINS));
    push_job.addr    = f2_read_r ? ADDR_W'(sel_idx) : slot;
    push_job.out_bin = f2_read_r ? f2_sel_r : BIN_W'(slot);
  end

  assign push = f2_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else begin
      if (in_fire && is_entry) begin
        start_r <= in_ch.timestamp;
      end
      if (adv) begin
        f1_valid_r <= in_fire && is_job;
        f2_valid_r <= f1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_diff_r  <= in_ch.timestamp - start_r;
      f1_read_r  <= is_read;
      f1_sel_r   <= in_ch.bin_select;
      f2_therm_r <= therm;
      f2_read_r  <= f1_read_r;
      f2_sel_r   <= f1_sel_r;
    end
  end

  a_entry_sets_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.cmd == CMD_ENTRY |=> start_r == $past(in_ch.timestamp))
    else $error("start time not taken from entry word");

  a_entry_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_fire && in_ch.cmd == CMD_ENTRY |=> !f1_valid_r)
    else $error("entry word produced a job");

endmodule

@@ rtl/lhist_back.sv @@
// Back end: bin counter read-modify-write with forwarding and result register.
module lhist_back
  import lhist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  lhist_job_t  job,
  output logic        pop,
  lhist_out_if.source out_ch
);

  logic [COUNT_W-1:0] hist_mem [NUM_BINS];
  logic [NUM_BINS-1:0] bin_vld_r;

  logic               b1_valid_r;
  logic               b1_read_r;
  logic               b1_oob_r;
  logic [ADDR_W-1:0]  b1_addr_r;
  logic [BIN_W-1:0]   b1_bin_r;
  logic [COUNT_W-1:0] mem_q_r;
  logic               ent_vld_r;
  logic               fwd_r;
  logic [COUNT_W-1:0] fwd_data_r;

  logic               out_valid_r;
  logic [BIN_W-1:0]   out_bin_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               b1_adv;
  logic               load;
  logic               wr_en;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] wr_data;
  logic [COUNT_W-1:0] res_count;

  assign b1_adv = b1_valid_r && (!out_valid_r || out_ch.ready);
  assign load   = job_valid && (!b1_valid_r || b1_adv);
  assign pop    = load;

  // a bin never written since reset counts as zero
  assign cur       = fwd_r ? fwd_data_r : (ent_vld_r ? mem_q_r : '0);
  assign wr_data   = cur + 1'b1;
  assign wr_en     = b1_adv && !b1_read_r;
  assign res_count = b1_read_r ? (b1_oob_r ? '0 : cur) : wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[b1_addr_r] <= wr_data;
    end
    if (load) begin
      mem_q_r <= hist_mem[job.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r   <= '0;
      b1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        bin_vld_r[b1_addr_r] <= 1'b1;
      end
      if (load || b1_adv) begin
        b1_valid_r <= load;
      end
      if (load) begin
        // same-bin write this edge: take its data, not the stale read
        fwd_r <= wr_en && (b1_addr_r == job.addr);
      end
      if (b1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b1_read_r  <= job.is_read;
      b1_oob_r   <= job.oob;
      b1_addr_r  <= job.addr;
      b1_bin_r   <= job.out_bin;
      ent_vld_r  <= bin_vld_r[job.addr];
      fwd_data_r <= wr_data;
    end
    if (b1_adv) begin
      out_bin_r   <= b1_bin_r;
      out_count_r <= res_count;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.bin   = out_bin_r;
  assign out_ch.count = out_count_r;

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> bin_vld_r[$past(b1_addr_r)]) else $error("written bin not marked valid");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_r) |-> $past(wr_en)) else $error("forward without a write");

endmodule

@@ bench/lhist_tracker_pkg.sv @@
// Scoreboard class that predicts and checks histogram results.
`timescale 1ns / 1ps
package lhist_tracker_pkg;
  import lhist_pkg::*;

  class hist_tracker;
    typedef struct {
      logic [BIN_W-1:0]   bin;
      logic [COUNT_W-1:0] count;
    } bin_count_t;

    bit [TS_W-1:0]    start_ns;
    bit [COUNT_W-1:0] bin_counts [NUM_BINS];
    bin_count_t       expected_q [$];
    int unsigned      errors;

    function new();
      start_ns = '0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // floor(log2(ms)) of the elapsed time, zero maps to bin 0, clamped
    function int unsigned elapsed_bin(bit [TS_W-1:0] ns);
      bit [TS_W-1:0] ms;
      int unsigned   b;
      ms = ns / 64'd1000000;
      b  = 0;
      while (ms > 1) begin
        ms = ms >> 1;
        b++;
      end
      if (b >= NUM_BINS) b = NUM_BINS - 1;
      return b;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, logic [TS_W-1:0] ts,
                            logic [SEL_W-1:0] sel);
      int unsigned b;
      bin_count_t  e;
      case (cmd)
        CMD_ENTRY: start_ns = ts;
        CMD_EXIT: begin
          b = elapsed_bin(ts - start_ns);
          bin_counts[b] = bin_counts[b] + 1;
          e.bin   = BIN_W'(b);
          e.count = bin_counts[b];
          expected_q.push_back(e);
        end
        CMD_READ: begin
          e.bin   = sel;
          e.count = (sel < NUM_BINS) ? bin_counts[sel] : '0;
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [BIN_W-1:0] bin, logic [COUNT_W-1:0] count);
      bin_count_t e;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result bin=%0d count=%0d", bin, count));
      end else begin
        e = expected_q.pop_front();
        if (bin !== e.bin)
          flag($sformatf("bin mismatch: expected %0d, got %0d", e.bin, bin));
        if (count !== e.count)
          flag($sformatf("count mismatch on bin %0d: expected %0d, got %0d",
                         e.bin, e.count, count));
      end
    endfunction
  endclass

endpackage

@@ bench/tb_log2_latency_histogram_top.sv @@
// Testbench top for the log2 latency histogram engine.
`timescale 1ns / 1ps
module tb_log2_latency_histogram_top;
  import lhist_pkg::*;
  import lhist_tracker_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned      TARGET_EVENTS = 1150;
  localparam logic [TS_W-1:0]  TS_MAX = '1;

  logic clk;
  logic rst_n;

  lhist_in_if  in_ch ();
  lhist_out_if out_ch ();

  log2_latency_histogram_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hist_tracker sb = new();

  bit          steady_flow;
  int unsigned events_sent;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_ENTRY;
    in_ch.timestamp  = '0;
    in_ch.bin_select = '0;
    out_ch.ready     = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.cmd, in_ch.timestamp, in_ch.bin_select);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.bin, out_ch.count);
    end
  end

  function automatic logic [TS_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // log-spread elapsed time so every bin, including the clamp, gets hits
  function automatic logic [TS_W-1:0] rand_elapsed();
    return rand64() >> $urandom_range(0, 63);
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TS_W-1:0] ts,
                           input logic [SEL_W-1:0] sel);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.timestamp  <= ts;
    in_ch.bin_select <= sel;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd != CMD_UNUSED) events_sent++;
  endtask

  // result side: random stall before each word, none in steady phases
  initial begin
    int unsigned stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    logic [TS_W-1:0] t0;
    int unsigned     next_switch;
    int unsigned     n_exits;
    steady_flow = 1'b0;
    events_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty bins, exit before any entry, bin edges, wrap, clamp
    send_word(CMD_READ, '0, 5'd0);
    send_word(CMD_READ, TS_MAX, 5'd31);
    send_word(CMD_EXIT, '0, 5'd0);
    send_word(CMD_EXIT, 64'd999_999, 5'd0);
    send_word(CMD_EXIT, 64'd1_000_000, 5'd31);
    send_word(CMD_EXIT, 64'd2_000_000, 5'd0);
    send_word(CMD_EXIT, 64'd3_999_999, 5'd0);
    send_word(CMD_EXIT, 64'd4_000_000, 5'd0);
    send_word(CMD_ENTRY, TS_MAX, 5'd31);
    send_word(CMD_EXIT, '0, 5'd0);
    send_word(CMD_EXIT, TS_MAX - 1, 5'd0);
    send_word(CMD_ENTRY, '0, 5'd0);
    send_word(CMD_EXIT, TS_MAX, 5'd0);
    send_word(CMD_EXIT, 64'd1_000_000 << 30, 5'd0);
    send_word(CMD_EXIT, 64'd1_000_000 << 31, 5'd0);
    send_word(CMD_UNUSED, TS_MAX, 5'd31);
    send_word(CMD_READ, '0, 5'd30);
    send_word(CMD_READ, '0, 5'd31);
    send_word(CMD_READ, '0, 5'd1);
    send_word(CMD_READ, '0, 5'd2);

    // random: mostly entry/exit pairs, reads, stray exits, some noise
    next_switch = events_sent + 100;
    while (events_sent < TARGET_EVENTS) begin
      if (events_sent >= next_switch) begin
        steady_flow = ~steady_flow;
        next_switch = events_sent + 100;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          t0 = rand64();
          send_word(CMD_ENTRY, t0, 5'($urandom()));
          n_exits = $urandom_range(1, 2);
          repeat (n_exits) begin
            if ($urandom_range(0, 3) == 0)
              send_word(CMD_READ, rand64(), 5'($urandom()));
            send_word(CMD_EXIT, t0 + rand_elapsed(), 5'($urandom()));
          end
        end
        6, 7: send_word(CMD_READ, rand64(), 5'($urandom()));
        8:    send_word(CMD_EXIT, rand64(), 5'($urandom()));
        default: begin
          if ($urandom_range(0, 1) == 0)
            send_word(CMD_UNUSED, rand64(), 5'($urandom()));
          else
            send_word(CMD_ENTRY, rand64(), 5'($urandom()));
        end
      endcase
    end
    in_ch.valid <= 1'b0;
    // let the monitor note the last accepted word before draining
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_log2_latency_histogram_top: clean");
    end else begin
      $display("tb_log2_latency_histogram_top: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_log2_latency_histogram_top: errors");
    $finish;
  end

endmodule
